@@ rtl/vrrp_pkg.sv @@
`default_nettype none
package vrrp_pkg;

  localparam int IntervalBits = 12;
  localparam int DownBits     = IntervalBits + 2;
  localparam int PrioBits     = 8;
  localparam int CompBits     = PrioBits + 1;
  localparam int ProdBits     = CompBits + IntervalBits;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = IntervalBits;

  localparam logic [PrioBits-1:0] PrioOwner = 8'd255;
  localparam logic [PrioBits-1:0] PrioZero  = 8'd0;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_BACKUP = 2'd1,
    MODE_MASTER = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADVERT  = 3'd1,
    OP_INVALID = 3'd2,
    OP_RELOAD  = 3'd3,
    OP_START   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ANN_NONE = 2'd0,
    ANN_ARP  = 2'd1,
    ANN_NA   = 2'd2
  } ann_e;

  typedef enum logic [1:0] {
    SCR_NONE   = 2'd0,
    SCR_MASTER = 2'd1,
    SCR_BACKUP = 2'd2
  } script_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PRIORITY = 3'd0,
    CFG_INTERVAL = 3'd1,
    CFG_PREEMPT  = 3'd2,
    CFG_VERSION  = 3'd3,
    CFG_FAMILY   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [PrioBits-1:0]     rx_priority;
    logic [IntervalBits-1:0] rx_interval;
    logic                    sender_addr_greater;
  } vrrp_in_t;

  typedef struct packed {
    logic [1:0] router_state;
    logic       send_advert;
    logic       send_zero_advert;
    logic [1:0] announce_kind;
    logic [1:0] script_event;
  } vrrp_out_t;

  typedef struct packed {
    logic [PrioBits-1:0]     local_priority;
    logic [IntervalBits-1:0] adv_interval;
    logic                    preempt_enable;
    logic                    version_three;
    logic                    family_ipv6;
  } vrrp_cfg_t;

  typedef struct packed {
    mode_e                   mode;
    logic [IntervalBits-1:0] learned_interval;
    logic [DownBits-1:0]     down_timer;
    logic                    down_on;
    logic [IntervalBits-1:0] advert_timer;
    logic                    advert_on;
  } vrrp_st_t;

endpackage
`default_nettype wire

@@ rtl/vrrp_fsm.sv @@
`default_nettype none
module vrrp_fsm import vrrp_pkg::*; (
  input  vrrp_st_t  st_i,
  input  vrrp_cfg_t cfg_i,
  input  vrrp_in_t  word_i,
  output vrrp_st_t  st_next_o,
  output vrrp_out_t res_o
);

  vrrp_st_t              nxt;
  logic                  arm_down;
  logic                  skew_only;
  logic [CompBits-1:0]   pri_comp;
  logic [ProdBits-1:0]   prod;
  logic [ProdBits-9:0]   skew;
  logic [DownBits:0]     down_full;

  always_comb begin
    nxt       = st_i;
    res_o     = '0;
    arm_down  = 1'b0;
    skew_only = 1'b0;
    case (word_i.op)
      OP_TICK: begin
        if (st_i.mode == MODE_BACKUP && st_i.down_on) begin
          if (st_i.down_timer <= DownBits'(1)) begin
            nxt.mode           = MODE_MASTER;
            res_o.send_advert  = 1'b1;
            res_o.announce_kind = cfg_i.family_ipv6 ? ANN_NA : ANN_ARP;
            res_o.script_event = SCR_MASTER;
            nxt.down_on        = 1'b0;
            nxt.down_timer     = '0;
            nxt.advert_timer   = cfg_i.adv_interval;
            nxt.advert_on      = 1'b1;
          end else begin
            nxt.down_timer = st_i.down_timer - DownBits'(1);
          end
        end else if (st_i.mode == MODE_MASTER && st_i.advert_on) begin
          if (st_i.advert_timer <= IntervalBits'(1)) begin
            res_o.send_advert = 1'b1;
            nxt.advert_timer  = cfg_i.adv_interval;
            nxt.advert_on     = 1'b1;
          end else begin
            nxt.advert_timer = st_i.advert_timer - IntervalBits'(1);
          end
        end
      end
      OP_ADVERT: begin
        if (st_i.mode == MODE_BACKUP) begin
          if (word_i.rx_priority == PrioZero) begin
            skew_only = 1'b1;
          end else if (!cfg_i.preempt_enable ||
                       word_i.rx_priority >= cfg_i.local_priority) begin
            if (cfg_i.version_three) begin
              nxt.learned_interval = word_i.rx_interval;
            end
            arm_down = 1'b1;
          end
        end else if (st_i.mode == MODE_MASTER) begin
          if (word_i.rx_priority == PrioZero) begin
            res_o.send_advert = 1'b1;
            nxt.advert_timer  = cfg_i.adv_interval;
            nxt.advert_on     = 1'b1;
          end else if (word_i.rx_priority > cfg_i.local_priority ||
                       (word_i.rx_priority == cfg_i.local_priority &&
                        word_i.sender_addr_greater)) begin
            nxt.mode           = MODE_BACKUP;
            res_o.script_event = SCR_BACKUP;
            if (cfg_i.version_three) begin
              nxt.learned_interval = word_i.rx_interval;
            end
            nxt.advert_on    = 1'b0;
            nxt.advert_timer = '0;
            arm_down         = 1'b1;
          end
        end
      end
      OP_RELOAD: begin
        if (st_i.mode == MODE_BACKUP) begin
          nxt.down_on    = 1'b0;
          nxt.down_timer = '0;
          nxt.mode       = MODE_INIT;
        end else if (st_i.mode == MODE_MASTER) begin
          nxt.advert_on          = 1'b0;
          nxt.advert_timer       = '0;
          res_o.send_zero_advert = 1'b1;
          res_o.script_event     = SCR_BACKUP;
          nxt.mode               = MODE_INIT;
        end
      end
      OP_START: begin
        if (st_i.mode == MODE_INIT) begin
          nxt.learned_interval = cfg_i.adv_interval;
          if (cfg_i.local_priority == PrioOwner) begin
            nxt.mode            = MODE_MASTER;
            res_o.send_advert   = 1'b1;
            res_o.announce_kind = cfg_i.family_ipv6 ? ANN_NA : ANN_ARP;
            res_o.script_event  = SCR_MASTER;
            nxt.down_on         = 1'b0;
            nxt.down_timer      = '0;
            nxt.advert_timer    = cfg_i.adv_interval;
            nxt.advert_on       = 1'b1;
          end else begin
            nxt.mode         = MODE_BACKUP;
            nxt.advert_on    = 1'b0;
            nxt.advert_timer = '0;
            arm_down         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_o.router_state = nxt.mode;
  end

  // skew and master-down from the interval this word leaves behind
  assign pri_comp  = CompBits'(256) - {1'b0, cfg_i.local_priority};
  assign prod      = ProdBits'(pri_comp) * ProdBits'(nxt.learned_interval);
  assign skew      = prod[ProdBits-1:8];
  assign down_full = ({2'b0, nxt.learned_interval, 1'b0} + (DownBits + 1)'(nxt.learned_interval))
                     + (DownBits + 1)'(skew);

  always_comb begin
    st_next_o = nxt;
    if (arm_down) begin
      st_next_o.down_timer = down_full[DownBits-1:0];
      st_next_o.down_on    = 1'b1;
    end else if (skew_only) begin
      st_next_o.down_timer = DownBits'(skew);
      st_next_o.down_on    = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vrrp_router_state_machine.sv @@
`default_nettype none
// channel  direction  payload     handshake
// in       input      vrrp_in_t   in_valid_i / in_stall_o
// out      output     vrrp_out_t  out_valid_o / out_stall_i
// cfg      input      index+data  cfg_we_i, no back-pressure
//
// one word per cycle sustained while the output is not stalled; an accepted word is
// held in the input register, then passes through the combinational state update
// into the result register
// reset puts the router in init with both timers stopped and the config registers at defaults
// a stall on the output holds the result; one more word waits in the input register
module vrrp_router_state_machine import vrrp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire vrrp_in_t               in_word_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output vrrp_out_t                   out_word_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  vrrp_cfg_t cfg_q;
  vrrp_st_t  st_q, st_d;
  vrrp_in_t  in_q;
  logic      in_valid_q;
  vrrp_out_t res_d, out_q;
  logic      out_valid_q;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_priority <= 8'd100;
      cfg_q.adv_interval   <= IntervalBits'(100);
      cfg_q.preempt_enable <= 1'b1;
      cfg_q.version_three  <= 1'b1;
      cfg_q.family_ipv6    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRIORITY: cfg_q.local_priority <= cfg_data_i[PrioBits-1:0];
        CFG_INTERVAL: cfg_q.adv_interval   <= cfg_data_i[IntervalBits-1:0];
        CFG_PREEMPT:  cfg_q.preempt_enable <= cfg_data_i[0];
        CFG_VERSION:  cfg_q.version_three  <= cfg_data_i[0];
        CFG_FAMILY:   cfg_q.family_ipv6    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  vrrp_fsm u_fsm (
    .st_i      (st_q),
    .cfg_i     (cfg_q),
    .word_i    (in_q),
    .st_next_o (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode             <= MODE_INIT;
      st_q.learned_interval <= '0;
      st_q.down_timer       <= '0;
      st_q.down_on          <= 1'b0;
      st_q.advert_timer     <= '0;
      st_q.advert_on        <= 1'b0;
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/vrrp_checker.sv @@
`default_nettype none
module vrrp_checker import vrrp_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire vrrp_out_t              out_word_o
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // no result rises without a word accepted earlier, held first in the input register
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding word");

  // shutdown advert only on leaving master, with the backup script
  a_zero_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.send_zero_advert |->
      out_word_o.router_state == MODE_INIT && out_word_o.script_event == SCR_BACKUP &&
      !out_word_o.send_advert)
    else $error("zero-priority advert in wrong context");

  // an announcement comes with taking over as master
  a_announce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.announce_kind != ANN_NONE |->
      out_word_o.router_state == MODE_MASTER && out_word_o.send_advert &&
      out_word_o.script_event == SCR_MASTER)
    else $error("announcement outside master takeover");

  // the master script is only run on becoming master
  a_script: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.script_event == SCR_MASTER |->
      out_word_o.announce_kind != ANN_NONE)
    else $error("master script without announcement");

endmodule

bind vrrp_router_state_machine vrrp_checker u_vrrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire
